// File: rtl/sst_pkg.sv
// Package for the source text tokenizer: word types, token codes, character
// constants and the functions that classify bytes and finish tokens.
// No dependencies; every other file imports it.
`default_nettype none

package sst_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [3:0]  subtype;
        logic [31:0] start_position;
        logic [31:0] token_line;
        logic [15:0] token_length;
        logic        end_of_stream;
    } token_word_t;

    typedef struct packed {
        logic        valid;
        token_word_t tok;
    } tok_slot_t;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_STRING = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_WORD   = 3'd3;
    localparam logic [2:0] MODE_OPER   = 3'd4;

    localparam logic [2:0] KIND_END     = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_INTEGER = 3'd2;
    localparam logic [2:0] KIND_FLOAT   = 3'd3;
    localparam logic [2:0] KIND_KEYWORD = 3'd4;
    localparam logic [2:0] KIND_IDENT   = 3'd5;
    localparam logic [2:0] KIND_OPER    = 3'd6;
    localparam logic [2:0] KIND_PUNCT   = 3'd7;

    localparam logic [3:0] SUB_NONE   = 4'd0;
    localparam logic [3:0] OP_ASSIGN  = 4'd0;
    localparam logic [3:0] OP_ADD     = 4'd1;
    localparam logic [3:0] OP_SUB     = 4'd2;
    localparam logic [3:0] OP_MUL     = 4'd3;
    localparam logic [3:0] OP_DIV     = 4'd4;
    localparam logic [3:0] OP_POW     = 4'd5;
    localparam logic [3:0] OP_NOT     = 4'd6;
    localparam logic [3:0] OP_LT      = 4'd7;
    localparam logic [3:0] OP_GT      = 4'd8;
    localparam logic [3:0] OP_EQ      = 4'd9;
    localparam logic [3:0] OP_UNKNOWN = 4'd14;

    localparam logic [3:0] PUNCT_DOT   = 4'd0;
    localparam logic [3:0] PUNCT_COMMA = 4'd1;
    localparam logic [3:0] PUNCT_SEMI  = 4'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;

    localparam int KW_COUNT = 6;
    localparam int PAIR_COUNT = 5;

    // Keyword text packed first byte lowest: if, else, elif, for, fun, ret.
    localparam logic [31:0] KW_HEAD [KW_COUNT] = '{
        32'h0000_6669, 32'h6573_6C65, 32'h6669_6C65,
        32'h0072_6F66, 32'h006E_7566, 32'h0074_6572
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3};

    // Two-byte operators in code order: ==, !=, >=, <=, ->.
    localparam logic [15:0] OP_PAIR [PAIR_COUNT] = '{
        16'h3D3D, 16'h3D21, 16'h3D3E, 16'h3D3C, 16'h3E2D
    };

    function automatic logic digit_byte(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH)
            || (c == CH_EQUAL) || (c == CH_CARET) || (c == CH_BANG)
            || (c == CH_LESS) || (c == CH_GREAT);
    endfunction

    // The cap argument is the token length, or 7 when it exceeds four.
    function automatic logic [3:0] oper_code(input logic [2:0] cap, input logic [31:0] head);
        logic [3:0] code;
        code = OP_UNKNOWN;
        if (cap == 3'd1) begin
            case (head[7:0])
                CH_EQUAL: code = OP_ASSIGN;
                CH_PLUS:  code = OP_ADD;
                CH_MINUS: code = OP_SUB;
                CH_STAR:  code = OP_MUL;
                CH_SLASH: code = OP_DIV;
                CH_CARET: code = OP_POW;
                CH_BANG:  code = OP_NOT;
                CH_LESS:  code = OP_LT;
                default:  code = OP_GT;
            endcase
        end else if (cap == 3'd2) begin
            for (int i = PAIR_COUNT - 1; i >= 0; i--) begin
                if (head[15:0] == OP_PAIR[i]) begin
                    code = OP_EQ + 4'(i);
                end
            end
        end
        return code;
    endfunction

    function automatic tok_slot_t close_token(
        input logic [2:0]  mode,
        input logic [31:0] start,
        input logic [15:0] len,
        input logic [2:0]  cap,
        input logic [31:0] head,
        input logic        point,
        input logic [31:0] line
    );
        tok_slot_t s;
        s.valid              = 1'b1;
        s.tok.token_kind     = KIND_END;
        s.tok.subtype        = SUB_NONE;
        s.tok.start_position = start;
        s.tok.token_line     = line;
        s.tok.token_length   = len;
        s.tok.end_of_stream  = 1'b0;
        case (mode)
            MODE_STRING: s.tok.token_kind = KIND_STRING;
            MODE_NUMBER: s.tok.token_kind = point ? KIND_FLOAT : KIND_INTEGER;
            MODE_WORD: begin
                s.tok.token_kind = KIND_IDENT;
                for (int i = KW_COUNT - 1; i >= 0; i--) begin
                    if ((cap == KW_LEN[i]) && (head == KW_HEAD[i])) begin
                        s.tok.token_kind = KIND_KEYWORD;
                        s.tok.subtype    = 4'(i);
                    end
                end
            end
            MODE_OPER: begin
                s.tok.token_kind = KIND_OPER;
                s.tok.subtype    = oper_code(cap, head);
            end
            default: s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sst_core.sv
// Scanner state and per-byte token logic of the source text tokenizer.
// Produces up to four candidate token slots per byte; depends on sst_pkg.
`default_nettype none

module sst_core
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire byte_word_t    byte_in,
    output tok_slot_t [3:0]    cand
);

    localparam logic [LENGTH_BITS-1:0] LEN_FOUR = LENGTH_BITS'(4);

    logic [2:0]               mode_reg, mode_next, mode_mid;
    logic [POSITION_BITS-1:0] start_reg, start_next, start_mid;
    logic [LENGTH_BITS-1:0]   len_reg, len_next, len_mid;
    logic                     point_reg, point_next, point_mid;
    logic [31:0]              head_reg, head_next, head_mid;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic [31:0]              line_reg, line_next, line_mid;

    logic       used;
    logic       close_a;
    logic       append_en;
    logic       punct_v;
    logic [3:0] punct_sub;
    logic [2:0] cap_reg;
    logic [2:0] cap_mid;
    logic [7:0] c;
    tok_slot_t  slot_a;
    tok_slot_t  slot_c;

    always_comb
    begin
        c         = byte_in.ch;
        mode_mid  = mode_reg;
        start_mid = start_reg;
        len_mid   = len_reg;
        head_mid  = head_reg;
        point_mid = point_reg;
        line_mid  = line_reg;
        used      = 1'b0;
        close_a   = 1'b0;
        append_en = 1'b0;
        punct_v   = 1'b0;
        punct_sub = PUNCT_DOT;

        cap_reg = (len_reg > LEN_FOUR) ? 3'd7 : 3'(len_reg);

        case (mode_reg)
            MODE_STRING:
            begin
                used = 1'b1;
                if (c == CH_DQUOTE) begin
                    close_a = 1'b1;
                end else begin
                    append_en = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (digit_byte(c) || (c == CH_DOT)) begin
                    used      = 1'b1;
                    append_en = 1'b1;
                    if (c == CH_DOT) begin
                        point_mid = 1'b1;
                    end
                end else begin
                    close_a = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (letter_byte(c) || digit_byte(c)) begin
                    used      = 1'b1;
                    append_en = 1'b1;
                end else begin
                    close_a = 1'b1;
                end
            end
            MODE_OPER:
            begin
                if (is_oper(c)) begin
                    used      = 1'b1;
                    append_en = 1'b1;
                end else begin
                    close_a = 1'b1;
                end
            end
            default: mode_mid = MODE_IDLE;
        endcase

        if (append_en) begin
            if (len_reg < LEN_FOUR) begin
                case (len_reg[1:0])
                    2'd0:    head_mid[7:0]   = head_reg[7:0] | c;
                    2'd1:    head_mid[15:8]  = head_reg[15:8] | c;
                    2'd2:    head_mid[23:16] = head_reg[23:16] | c;
                    default: head_mid[31:24] = head_reg[31:24] | c;
                endcase
            end
            if (len_reg != '1) begin
                len_mid = len_reg + LENGTH_BITS'(1);
            end
        end
        if (close_a) begin
            mode_mid = MODE_IDLE;
        end

        slot_a = close_token(mode_reg, 32'(start_reg), 16'(len_reg), cap_reg,
                             head_reg, point_reg, line_reg);
        slot_a.valid = close_a & slot_a.valid;

        if (!used) begin
            if (c == CH_NL) begin
                if (line_mid != '1) begin
                    line_mid = line_mid + 32'd1;
                end
            end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                mode_mid  = MODE_STRING;
                start_mid = pos_reg + POSITION_BITS'(1);
                len_mid   = '0;
                head_mid  = '0;
                point_mid = 1'b0;
            end else if (digit_byte(c) || letter_byte(c) || is_oper(c)) begin
                if (digit_byte(c)) begin
                    mode_mid = MODE_NUMBER;
                end else if (letter_byte(c)) begin
                    mode_mid = MODE_WORD;
                end else begin
                    mode_mid = MODE_OPER;
                end
                start_mid = pos_reg;
                len_mid   = LENGTH_BITS'(1);
                head_mid  = {24'd0, c};
                point_mid = 1'b0;
            end else if (c == CH_DOT) begin
                punct_v = 1'b1;
            end else if (c == CH_COMMA) begin
                punct_v   = 1'b1;
                punct_sub = PUNCT_COMMA;
            end else if (c == CH_SEMI) begin
                punct_v   = 1'b1;
                punct_sub = PUNCT_SEMI;
            end
        end

        cand[1].valid              = punct_v;
        cand[1].tok.token_kind     = KIND_PUNCT;
        cand[1].tok.subtype        = punct_sub;
        cand[1].tok.start_position = 32'(pos_reg);
        cand[1].tok.token_line     = line_mid;
        cand[1].tok.token_length   = 16'd1;
        cand[1].tok.end_of_stream  = 1'b0;

        pos_inc = pos_reg + POSITION_BITS'(1);
        cap_mid = (len_mid > LEN_FOUR) ? 3'd7 : 3'(len_mid);

        slot_c = close_token(mode_mid, 32'(start_mid), 16'(len_mid), cap_mid,
                             head_mid, point_mid, line_mid);
        slot_c.valid = byte_in.last_byte & slot_c.valid;

        cand[0] = slot_a;
        cand[2] = slot_c;

        cand[3].valid              = byte_in.last_byte;
        cand[3].tok.token_kind     = KIND_END;
        cand[3].tok.subtype        = SUB_NONE;
        cand[3].tok.start_position = 32'(pos_inc);
        cand[3].tok.token_line     = line_mid;
        cand[3].tok.token_length   = 16'd0;
        cand[3].tok.end_of_stream  = 1'b1;

        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        point_next = point_reg;
        head_next  = head_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        if (step) begin
            if (byte_in.last_byte) begin
                mode_next  = MODE_IDLE;
                start_next = '0;
                len_next   = '0;
                point_next = 1'b0;
                head_next  = '0;
                pos_next   = '0;
                line_next  = 32'd1;
            end else begin
                mode_next  = mode_mid;
                start_next = start_mid;
                len_next   = len_mid;
                point_next = point_mid;
                head_next  = head_mid;
                pos_next   = pos_inc;
                line_next  = line_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            point_reg <= 1'b0;
            head_reg  <= '0;
            pos_reg   <= '0;
            line_reg  <= 32'd1;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            point_reg <= point_next;
            head_reg  <= head_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sst_queue.sv
// Four-entry shifting result queue of the source text tokenizer; entry zero
// drives the token channel. Takes up to four candidate slots per cycle; uses sst_pkg.
`default_nettype none

module sst_queue
    import sst_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tok_slot_t [3:0] cand,
    input  wire logic            tok_stall,
    output logic                 tok_valid,
    output token_word_t          tok_word,
    output logic                 room
);

    logic [2:0]  count_reg, count_next;
    token_word_t entry_reg  [4];
    token_word_t entry_next [4];
    logic        pop;
    logic [2:0]  base;
    logic [2:0]  offs;

    always_comb
    begin
        pop  = (count_reg != 3'd0) && !tok_stall;
        base = count_reg - {2'b00, pop};
        room = (base <= 3'd1);

        for (int i = 0; i < 4; i++) begin
            if (pop && (i < 3)) begin
                entry_next[i] = entry_reg[(i < 3) ? i + 1 : i];
            end else begin
                entry_next[i] = entry_reg[i];
            end
        end

        offs = base;
        for (int k = 0; k < 4; k++) begin
            if (push && cand[k].valid) begin
                entry_next[offs[1:0]] = cand[k].tok;
                offs = offs + 3'd1;
            end
        end
        count_next = offs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign tok_valid = (count_reg != 3'd0);
    assign tok_word  = entry_reg[0];

endmodule

`default_nettype wire

// File: rtl/source_text_tokenizer.sv
// Source text tokenizer: byte input register, scanner core and result queue.
// Depends on sst_pkg, sst_core and sst_queue.
//
// Usage: source text enters one byte per word on the byte channel
// (byte_valid, byte_stall, byte_word); last_byte marks the final byte of a
// text. Tokens leave one per word on the token channel (token_valid,
// token_stall, token_word). A byte is taken into the input register, and once
// the queue has room the scanner turns it into zero to three tokens that are
// written into a four-entry queue whose head drives the token channel.
// One byte is accepted every cycle while the queue holds at most one token
// after the current pop; while the tokens of a byte that yields several
// drain, the input register waits for queue room.
// After the final byte an END token follows and the scanner state returns to
// position 0, line 1. Reset empties the input register and the queue.
// A stall on the token channel holds the head token; bytes keep being taken
// until the queue holds two or more tokens, then byte_stall rises.
`default_nettype none

module source_text_tokenizer
    import sst_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_word_t byte_word,
    output logic            token_valid,
    input  wire logic       token_stall,
    output token_word_t     token_word
);

    logic            full_reg, full_next;
    byte_word_t      byte_reg;
    logic            room;
    logic            step;
    logic            accept;
    tok_slot_t [3:0] cand;

    assign step       = full_reg && room;
    assign byte_stall = full_reg && !room;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        full_next = full_reg;
        if (accept) begin
            full_next = 1'b1;
        end else if (step) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg <= byte_word;
        end
    end

    sst_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_reg),
        .cand    (cand)
    );

    sst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .cand      (cand),
        .tok_stall (token_stall),
        .tok_valid (token_valid),
        .tok_word  (token_word),
        .room      (room)
    );

endmodule

`default_nettype wire
